### hw/rtl/ps2_scancode_key_tracker_unit_defines.svh
// Assertion macros for the PS/2 scan code key tracker.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PS2_SCANCODE_KEY_TRACKER_UNIT_DEFINES_SVH
`define PS2_SCANCODE_KEY_TRACKER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted.
`define PS2K_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds while reset is asserted.
`define PS2K_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PS2K_ASSERT(lbl, clk, rst_n, prop, msg)
`define PS2K_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/ps2k_pkg.sv
// Types, constants and scan code decode functions for the PS/2 key tracker.
// No dependencies; used by the channel interfaces and the top level.
package ps2k_pkg;

  localparam int unsigned NumSrc   = 2;
  localparam int unsigned SrcW     = 1;
  localparam int unsigned NumKeys  = 6;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeSetW = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 2;

  typedef logic [KeyW-1:0]    key_t;
  typedef logic [NumKeys-1:0] keymask_t;
  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [CodeSetW-1:0] code_set_t;

  localparam key_t KeyNone = 3'd7;

  // Code set register values
  localparam code_set_t CsOff  = 2'd0;
  localparam code_set_t CsSet1 = 2'd1;
  localparam code_set_t CsSet2 = 2'd2;

  // Protocol bytes
  localparam byte_t BSet1Brk  = 8'h80;
  localparam byte_t BExt      = 8'hE0;
  localparam byte_t BPause    = 8'hE1;
  localparam byte_t BBreak    = 8'hF0;
  localparam byte_t BPrtScRel = 8'hB7;
  localparam byte_t BFakeShft = 8'h2A;
  localparam byte_t BS2PrtSc  = 8'h7C;
  localparam byte_t BS2FakeSh = 8'h12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_SOURCES = 2'd0,
    CFG_CODE_SET_0     = 2'd1,
    CFG_CODE_SET_1     = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_SCAN    = 1'b0,
    CMD_CONSUME = 1'b1
  } cmd_e;

  // Parser state; sequence states step by one on each matching byte.
  typedef enum logic [4:0] {
    PS_IDLE        = 5'd0,
    PS_S1_E0       = 5'd1,
    PS_S1_PSM      = 5'd2,
    PS_S1_PSM2     = 5'd3,
    PS_S1_PSR      = 5'd4,
    PS_S1_PSR2     = 5'd5,
    PS_S1_PAUSE    = 5'd6,
    PS_S1_PAUSE2   = 5'd7,
    PS_S1_PAUSE3   = 5'd8,
    PS_S1_PAUSE4   = 5'd9,
    PS_S1_PAUSE5   = 5'd10,
    PS_S2_BRK      = 5'd11,
    PS_S2_E0       = 5'd12,
    PS_S2_E0BRK    = 5'd13,
    PS_S2_PSM      = 5'd14,
    PS_S2_PSM2     = 5'd15,
    PS_S2_PSR      = 5'd16,
    PS_S2_PSR2     = 5'd17,
    PS_S2_PSR3     = 5'd18,
    PS_S2_PAUSE    = 5'd19,
    PS_S2_PAUSE2   = 5'd20,
    PS_S2_PAUSE3   = 5'd21,
    PS_S2_PAUSE4   = 5'd22,
    PS_S2_PAUSE5   = 5'd23,
    PS_S2_PAUSE6   = 5'd24,
    PS_S2_PAUSE7   = 5'd25,
    PS_S3_BRK      = 5'd26
  } ps_e;

  typedef struct packed {
    ps_e  next;
    key_t key;   // KeyNone when no key changes
    logic val;   // 1 = press, 0 = release
  } parse_t;

  // Byte expected in a sequence state; zero outside sequences.
  function automatic byte_t seq_expect(ps_e st);
    case (st)
      PS_S1_PSM:    return 8'hE0;
      PS_S1_PSM2:   return 8'h37;
      PS_S1_PSR:    return 8'hE0;
      PS_S1_PSR2:   return 8'hAA;
      PS_S1_PAUSE:  return 8'h1D;
      PS_S1_PAUSE2: return 8'h45;
      PS_S1_PAUSE3: return 8'hE1;
      PS_S1_PAUSE4: return 8'h9D;
      PS_S1_PAUSE5: return 8'hC5;
      PS_S2_PSM:    return 8'hE0;
      PS_S2_PSM2:   return 8'h7C;
      PS_S2_PSR:    return 8'hE0;
      PS_S2_PSR2:   return 8'hF0;
      PS_S2_PSR3:   return 8'h12;
      PS_S2_PAUSE:  return 8'h14;
      PS_S2_PAUSE2: return 8'h77;
      PS_S2_PAUSE3: return 8'hE1;
      PS_S2_PAUSE4: return 8'hF0;
      PS_S2_PAUSE5: return 8'h14;
      PS_S2_PAUSE6: return 8'hF0;
      PS_S2_PAUSE7: return 8'h77;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic logic seq_last(ps_e st);
    case (st) inside
      PS_S1_PSM2, PS_S1_PSR2, PS_S1_PAUSE5,
      PS_S2_PSM2, PS_S2_PSR3, PS_S2_PAUSE7: return 1'b1;
      default:                              return 1'b0;
    endcase
  endfunction

  function automatic key_t set1_key(byte_t c);
    case (c) inside
      8'h11, 8'h48: return 3'd0;
      8'h1F, 8'h50: return 3'd1;
      8'h1E, 8'h4B: return 3'd2;
      8'h20, 8'h4D: return 3'd3;
      8'h13:        return 3'd4;
      8'h30:        return 3'd5;
      default:      return KeyNone;
    endcase
  endfunction

  function automatic key_t set1_ext_key(byte_t c);
    case (c)
      8'h48:   return 3'd0;
      8'h50:   return 3'd1;
      8'h4B:   return 3'd2;
      8'h4D:   return 3'd3;
      default: return KeyNone;
    endcase
  endfunction

  function automatic key_t set2_ext_key(byte_t c);
    case (c)
      8'h75:   return 3'd0;
      8'h72:   return 3'd1;
      8'h6B:   return 3'd2;
      8'h74:   return 3'd3;
      default: return KeyNone;
    endcase
  endfunction

  function automatic key_t set2_key(byte_t c);
    case (c)
      8'h1D:   return 3'd0;
      8'h1B:   return 3'd1;
      8'h1C:   return 3'd2;
      8'h23:   return 3'd3;
      8'h2D:   return 3'd4;
      8'h32:   return 3'd5;
      default: return set2_ext_key(c);
    endcase
  endfunction

  function automatic key_t set3_key(byte_t c);
    case (c)
      8'h60:   return 3'd1;
      8'h61:   return 3'd2;
      8'h63:   return 3'd0;
      8'h6A:   return 3'd3;
      default: return set2_key(c);
    endcase
  endfunction

  function automatic parse_t set2_code(byte_t b, logic val);
    parse_t r;
    r.next = PS_IDLE;
    r.key  = KeyNone;
    r.val  = val;
    if (b == BExt) begin
      r.next = PS_S2_E0;
    end else if (b == BPause) begin
      r.next = PS_S2_PAUSE;
    end else begin
      r.key = set2_key(b);
    end
    return r;
  endfunction

  function automatic parse_t set2_ext_code(byte_t b, logic val);
    parse_t r;
    r.next = PS_IDLE;
    r.key  = KeyNone;
    r.val  = val;
    if (b == BS2FakeSh) begin
      r.next = PS_S2_PSM;
    end else if (b == BS2PrtSc) begin
      r.next = val ? PS_IDLE : PS_S2_PSR;
    end else begin
      r.key = set2_ext_key(b);
    end
    return r;
  endfunction

  // One byte through one source's parser: next state and key change.
  function automatic parse_t parse_byte(ps_e st, code_set_t mode, byte_t b);
    parse_t r;
    byte_t  exp;
    byte_t  c;
    logic   val;
    r.next = PS_IDLE;
    r.key  = KeyNone;
    r.val  = 1'b0;
    exp    = seq_expect(st);
    c      = b;
    val    = 1'b1;
    if (exp != 8'h00) begin
      if (b == exp && !seq_last(st)) begin
        r.next = ps_e'(st + 5'd1);
      end
    end else begin
      case (st)
        PS_IDLE: begin
          if (mode == CsSet1) begin
            if (b == BExt) begin
              r.next = PS_S1_E0;
            end else if (b == BPause) begin
              r.next = PS_S1_PAUSE;
            end else begin
              val   = (b <= BSet1Brk);
              c     = val ? b : b - BSet1Brk;
              r.key = set1_key(c);
              r.val = val;
            end
          end else if (mode == CsSet2) begin
            if (b == BBreak) begin
              r.next = PS_S2_BRK;
            end else begin
              r = set2_code(b, 1'b1);
            end
          end else begin
            if (b == BBreak) begin
              r.next = PS_S3_BRK;
            end else begin
              r.key = set3_key(b);
              r.val = 1'b1;
            end
          end
        end
        PS_S1_E0: begin
          val = !(b > BSet1Brk && b != BPrtScRel);
          c   = val ? b : b - BSet1Brk;
          if (c == BFakeShft) begin
            r.next = PS_S1_PSM;
          end else if (c == BPrtScRel) begin
            r.next = PS_S1_PSR;
          end else begin
            r.key = set1_ext_key(c);
            r.val = val;
          end
        end
        PS_S2_BRK: begin
          r = set2_code(b, 1'b0);
        end
        PS_S2_E0: begin
          if (b == BBreak) begin
            r.next = PS_S2_E0BRK;
          end else begin
            r = set2_ext_code(b, 1'b1);
          end
        end
        PS_S2_E0BRK: begin
          r = set2_ext_code(b, 1'b0);
        end
        PS_S3_BRK: begin
          r.key = set3_key(b);
          r.val = 1'b0;
        end
        default: begin
          r.next = PS_IDLE;
        end
      endcase
    end
    return r;
  endfunction

endpackage

### hw/rtl/ps2k_if.sv
// Valid/ready channel interfaces for the PS/2 key tracker: item in, result out.
// Depends on ps2k_pkg for field widths.
interface ps2k_in_if;
  import ps2k_pkg::*;
  logic  valid;
  logic  ready;
  logic  cmd;
  logic  src;
  byte_t scan_byte;
  key_t  key_index;

  modport source (output valid, output cmd, output src, output scan_byte,
                  output key_index, input ready);
  modport sink   (input valid, input cmd, input src, input scan_byte,
                  input key_index, output ready);
endinterface

interface ps2k_out_if;
  import ps2k_pkg::*;
  logic     valid;
  logic     ready;
  keymask_t keys_held;
  logic     key_was_pressed;
  logic     mid_sequence;

  modport source (output valid, output keys_held, output key_was_pressed,
                  output mid_sequence, input ready);
  modport sink   (input valid, input keys_held, input key_was_pressed,
                  input mid_sequence, output ready);
endinterface

### hw/rtl/ps2_scancode_key_tracker_unit.sv
// PS/2 scan code key tracker: two parsers, six-key held mask, consume command.
// Depends on ps2k_pkg, the ps2k_in_if / ps2k_out_if channels and the
// assertion macro header.
//
// Flow: an accepted beat is registered in the input register and then moves to
// the result register, where it is held until the sink takes it.
// Throughput: one beat per cycle unless the sink holds off; the input register and result
// register form a two-entry pipeline, so a new beat enters while a result waits.
// Reset: asynchronous, active low; both parsers idle, no key held,
// active_sources 0, code sets 1, pipeline empty.
`include "ps2_scancode_key_tracker_unit_defines.svh"

module ps2_scancode_key_tracker_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ps2k_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ps2k_pkg::CfgDataW-1:0]  cfg_data_i,
  ps2k_in_if.sink                        in_i,
  ps2k_out_if.source                     out_o
);
  import ps2k_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CodeSetW-1:0] act_q;
  code_set_t           cs_q [NumSrc];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      for (int s = 0; s < NumSrc; s++) begin
        cs_q[s] <= CsSet1;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ACTIVE_SOURCES: act_q    <= cfg_data_i;
        CFG_CODE_SET_0:     cs_q[0]  <= cfg_data_i;
        CFG_CODE_SET_1:     cs_q[1]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register (stage 1) feeding the result register.
  // Stage 1 drains whenever the result register is empty or being taken.
  // ---------------------------------------------------------------------
  logic s1_vld_q, out_vld_q;
  logic s2_ready, s2_load, in_ready, in_acc;

  assign s2_ready = !out_vld_q || out_o.ready;
  assign s2_load  = s1_vld_q && s2_ready;
  assign in_ready = !s1_vld_q || s2_ready;
  assign in_acc   = in_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s2_load) begin
        s1_vld_q <= 1'b0;
      end
      if (s2_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Stage 1 payload: capture the beat as it is accepted.
  logic  s1_cmd_q;
  logic  s1_src_q;
  byte_t s1_byte_q;
  key_t  s1_key_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= in_i.cmd;
      s1_src_q  <= in_i.src;
      s1_byte_q <= in_i.scan_byte;
      s1_key_q  <= in_i.key_index;
    end
  end

  // ---------------------------------------------------------------------
  // Per-item work: one parser step or one consume against the held mask.
  // ---------------------------------------------------------------------
  ps_e      ps_q [NumSrc];
  ps_e      ps_d [NumSrc];
  keymask_t keys_q, keys_d;

  logic     src_active, scan_upd, is_consume, was_pressed, mid_nxt;
  ps_e      cur_ps;
  parse_t   pr;
  keymask_t key_mask, cons_mask, keys_item;

  always_comb begin
    // Ignore bytes from detached keyboards and from a source with no code set.
    src_active = ({1'b0, s1_src_q} < act_q) && (cs_q[s1_src_q] != CsOff);
    scan_upd   = (s1_cmd_q == CMD_SCAN) && src_active;
    cur_ps     = ps_q[s1_src_q];
    pr         = parse_byte(cur_ps, cs_q[s1_src_q], s1_byte_q);

    is_consume = (s1_cmd_q == CMD_CONSUME) && (s1_key_q < KeyW'(NumKeys));
    cons_mask  = is_consume ? keymask_t'(1) << s1_key_q : '0;
    was_pressed = |(keys_q & cons_mask);

    // Key change from the parser, applied only for a valid key code.
    key_mask = (scan_upd && pr.key < KeyW'(NumKeys)) ? keymask_t'(1) << pr.key : '0;

    keys_item = keys_q & ~cons_mask;
    if (pr.val) begin
      keys_item = keys_item | key_mask;
    end else begin
      keys_item = keys_item & ~key_mask;
    end

    mid_nxt = (scan_upd ? pr.next : cur_ps) != PS_IDLE;

    keys_d = s2_load ? keys_item : keys_q;
    for (int s = 0; s < NumSrc; s++) begin
      ps_d[s] = ps_q[s];
      if (s2_load && scan_upd && (s1_src_q == SrcW'(s))) begin
        ps_d[s] = pr.next;
      end
    end
    // A code set write restarts that source's parser.
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CODE_SET_0: ps_d[0] = PS_IDLE;
        CFG_CODE_SET_1: ps_d[1] = PS_IDLE;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
      for (int s = 0; s < NumSrc; s++) begin
        ps_q[s] <= PS_IDLE;
      end
    end else begin
      keys_q <= keys_d;
      for (int s = 0; s < NumSrc; s++) begin
        ps_q[s] <= ps_d[s];
      end
    end
  end

  // Result register: hold the beat until the sink takes it.
  keymask_t out_keys_q;
  logic     out_was_q, out_mid_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_keys_q <= keys_item;
      out_was_q  <= was_pressed;
      out_mid_q  <= mid_nxt;
    end
  end

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_vld_q;
  assign out_o.keys_held       = out_keys_q;
  assign out_o.key_was_pressed = out_was_q;
  assign out_o.mid_sequence    = out_mid_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `PS2K_ASSERT(a_consume_clears, clk_i, rst_ni,
               s2_load |=> (keys_q & $past(cons_mask)) == '0,
               "consumed key still held")
  `PS2K_ASSERT(a_was_only_consume, clk_i, rst_ni,
               s2_load && s1_cmd_q == CMD_SCAN |=> !out_was_q,
               "key_was_pressed set on a scan byte")
  `PS2K_ASSERT(a_ignored_keeps_parsers, clk_i, rst_ni,
               s2_load && s1_cmd_q == CMD_SCAN && !src_active && !cfg_we_i |=>
               $stable(ps_q[0]) && $stable(ps_q[1]),
               "ignored byte moved a parser")
  `PS2K_ASSERT(a_stall_full, clk_i, rst_ni,
               !in_ready |-> s1_vld_q && out_vld_q && !out_o.ready,
               "input stalled with room in the pipeline")
  `PS2K_ASSERT_ALWAYS(a_reset_empty, clk_i,
                      !rst_ni |-> !s1_vld_q && !out_vld_q,
                      "pipeline not empty in reset")

endmodule

### tb/tb_ps2_scancode_key_tracker_unit.sv
// Self-checking testbench for the PS/2 scan code key tracker.
// Depends on ps2k_pkg, the ps2k_in_if / ps2k_out_if channels and the
// ps2_scancode_key_tracker_unit RTL with its assertion macro header; needs nothing else.
`timescale 1ns / 100ps

module tb_ps2_scancode_key_tracker_unit;
  import ps2k_pkg::*;

  // Key indexes of the held mask
  localparam key_t KeyUp    = 3'd0;
  localparam key_t KeyDown  = 3'd1;
  localparam key_t KeyLeft  = 3'd2;
  localparam key_t KeyRight = 3'd3;
  localparam key_t KeyR     = 3'd4;
  localparam key_t KeyB     = 3'd5;

  // The package names sets 0 to 2 only; set 3 is the remaining register value
  localparam code_set_t CsSet3 = 2'd3;

  // Lookup tables a scan code can be decoded against
  typedef enum int {
    KT_SET1,
    KT_SET1_EXT,
    KT_SET2,
    KT_SET2_EXT,
    KT_SET3
  } key_table_e;

  typedef struct packed {
    keymask_t keys;
    logic     was;
    logic     mid;
  } key_report_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ps2k_in_if  in_ch ();
  ps2k_out_if out_ch ();

  ps2_scancode_key_tracker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Shadow copy of the block: held mask, one parser per keyboard, registers
  keymask_t   held_mask;
  ps_e        parse_st [NumSrc];
  logic [1:0] num_sources;
  code_set_t  src_set [NumSrc];

  // Reports still owed by the block, oldest first
  key_report_t pending_reports [$];

  // Bytes of the scan sequence being sent
  byte_t word_q [$];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_request;
  int stall_left;
  int fail_count;
  int beat_count;
  int consume_count;
  int reg_writes;
  int input_stalls;
  int report_count;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run well above the slowest legal pacing
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Key decode: map a code byte to a key index for one table
  // ---------------------------------------------------------------------------
  function automatic key_t key_lookup(key_table_e tbl, byte_t c);
    key_t k;
    k = KeyNone;
    if (tbl == KT_SET1 || tbl == KT_SET1_EXT) begin
      // Set 1 arrows exist in both the plain and the extended table
      case (c)
        8'h48: k = KeyUp;
        8'h50: k = KeyDown;
        8'h4B: k = KeyLeft;
        8'h4D: k = KeyRight;
        default: ;
      endcase
      if (tbl == KT_SET1) begin
        case (c)
          8'h11: k = KeyUp;
          8'h1F: k = KeyDown;
          8'h1E: k = KeyLeft;
          8'h20: k = KeyRight;
          8'h13: k = KeyR;
          8'h30: k = KeyB;
          default: ;
        endcase
      end
    end else begin
      // Set 2 extended arrows also decode without the E0 prefix, and set 3
      // falls back on the whole set 2 table
      case (c)
        8'h75: k = KeyUp;
        8'h72: k = KeyDown;
        8'h6B: k = KeyLeft;
        8'h74: k = KeyRight;
        default: ;
      endcase
      if (tbl != KT_SET2_EXT) begin
        case (c)
          8'h1D: k = KeyUp;
          8'h1B: k = KeyDown;
          8'h1C: k = KeyLeft;
          8'h23: k = KeyRight;
          8'h2D: k = KeyR;
          8'h32: k = KeyB;
          default: ;
        endcase
      end
      if (tbl == KT_SET3) begin
        case (c)
          8'h63: k = KeyUp;
          8'h60: k = KeyDown;
          8'h61: k = KeyLeft;
          8'h6A: k = KeyRight;
          default: ;
        endcase
      end
    end
    return k;
  endfunction

  function automatic void update_key(key_t k, logic press);
    if (k < NumKeys) held_mask[k] = press;
  endfunction

  // {last byte of its sequence, byte awaited}; zero outside swallowed sequences
  function automatic logic [8:0] awaited_byte(ps_e st);
    case (st)
      PS_S1_PSM, PS_S1_PSR,
      PS_S2_PSM, PS_S2_PSR:   return {1'b0, BExt};
      PS_S1_PSM2:             return {1'b1, 8'h37};
      PS_S1_PSR2:             return {1'b1, 8'hAA};
      PS_S1_PAUSE:            return {1'b0, 8'h1D};
      PS_S1_PAUSE2:           return {1'b0, 8'h45};
      PS_S1_PAUSE3:           return {1'b0, BPause};
      PS_S1_PAUSE4:           return {1'b0, 8'h9D};
      PS_S1_PAUSE5:           return {1'b1, 8'hC5};
      PS_S2_PSM2:             return {1'b1, BS2PrtSc};
      PS_S2_PSR2:             return {1'b0, BBreak};
      PS_S2_PSR3:             return {1'b1, BS2FakeSh};
      PS_S2_PAUSE:            return {1'b0, 8'h14};
      PS_S2_PAUSE2:           return {1'b0, 8'h77};
      PS_S2_PAUSE3:           return {1'b0, BPause};
      PS_S2_PAUSE4:           return {1'b0, BBreak};
      PS_S2_PAUSE5:           return {1'b0, 8'h14};
      PS_S2_PAUSE6:           return {1'b0, BBreak};
      PS_S2_PAUSE7:           return {1'b1, 8'h77};
      default:                return 9'h000;
    endcase
  endfunction

  // Set 2 code after idle or after a break prefix
  function automatic ps_e set2_plain_step(byte_t b, logic press);
    if (b == BExt) return PS_S2_E0;
    if (b == BPause) return PS_S2_PAUSE;
    update_key(key_lookup(KT_SET2, b), press);
    return PS_IDLE;
  endfunction

  // Set 2 code after E0 (and maybe E0 F0)
  function automatic ps_e set2_ext_step(byte_t b, logic press);
    if (b == BS2FakeSh) return PS_S2_PSM;
    if (b == BS2PrtSc) return press ? PS_IDLE : PS_S2_PSR;
    update_key(key_lookup(KT_SET2_EXT, b), press);
    return PS_IDLE;
  endfunction

  // Advance one keyboard's parser by one byte and apply any key change
  function automatic ps_e next_parse_state(ps_e st, code_set_t cs, byte_t b);
    logic [8:0] seq;
    logic       press;
    byte_t      code;
    seq = awaited_byte(st);
    if (seq[7:0] != 8'h00) begin
      // Inside a swallowed sequence: step on a match, drop to idle otherwise
      if (b == seq[7:0] && !seq[8]) return ps_e'(st + 5'd1);
      return PS_IDLE;
    end
    case (st)
      PS_IDLE: begin
        if (cs == CsSet1) begin
          if (b == BExt) return PS_S1_E0;
          if (b == BPause) return PS_S1_PAUSE;
          press = (b <= BSet1Brk);
          code  = press ? b : b - BSet1Brk;
          update_key(key_lookup(KT_SET1, code), press);
          return PS_IDLE;
        end
        if (cs == CsSet2) return (b == BBreak) ? PS_S2_BRK : set2_plain_step(b, 1'b1);
        if (b == BBreak) return PS_S3_BRK;
        update_key(key_lookup(KT_SET3, b), 1'b1);
        return PS_IDLE;
      end
      PS_S1_E0: begin
        // Print-screen release byte keeps its high bit
        press = !(b > BSet1Brk && b != BPrtScRel);
        code  = press ? b : b - BSet1Brk;
        if (code == BFakeShft) return PS_S1_PSM;
        if (code == BPrtScRel) return PS_S1_PSR;
        update_key(key_lookup(KT_SET1_EXT, code), press);
        return PS_IDLE;
      end
      PS_S2_BRK:   return set2_plain_step(b, 1'b0);
      PS_S2_E0:    return (b == BBreak) ? PS_S2_E0BRK : set2_ext_step(b, 1'b1);
      PS_S2_E0BRK: return set2_ext_step(b, 1'b0);
      PS_S3_BRK: begin
        update_key(key_lookup(KT_SET3, b), 1'b0);
        return PS_IDLE;
      end
      default:     return PS_IDLE;
    endcase
  endfunction

  // Apply one accepted beat to the shadow state and form the report it owes
  function automatic key_report_t track_beat(cmd_e c, logic src, byte_t b, key_t k);
    key_report_t r;
    r.was = 1'b0;
    if (c == CMD_CONSUME) begin
      if (k < NumKeys) begin
        r.was        = held_mask[k];
        held_mask[k] = 1'b0;
      end
    end else if (src < num_sources && src_set[src] != CsOff) begin
      parse_st[src] = next_parse_state(parse_st[src], src_set[src], b);
    end
    r.keys = held_mask;
    r.mid  = (parse_st[src] != PS_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off on request, report checking
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk_i);
      if (stall_request != 0) begin
        stall_left    = stall_request;
        stall_request = 0;
      end
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : report_checker
    key_report_t want;
    if (rst_ni && in_ch.valid && !in_ch.ready) input_stalls++;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      report_count++;
      if (pending_reports.size() == 0) begin
        $error("report %0d arrived with nothing outstanding", report_count);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.keys_held !== want.keys) begin
          $error("keys_held: expected %02h, got %02h", want.keys, out_ch.keys_held);
          fail_count++;
        end
        if (out_ch.key_was_pressed !== want.was) begin
          $error("key_was_pressed: expected %0b, got %0b", want.was,
                 out_ch.key_was_pressed);
          fail_count++;
        end
        if (out_ch.mid_sequence !== want.mid) begin
          $error("mid_sequence: expected %0b, got %0b", want.mid, out_ch.mid_sequence);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Every task below is entered at a falling edge and returns at
  // one; a beat leaves valid high so back-to-back beats never toggle it.
  // ---------------------------------------------------------------------------
  task automatic send_beat(cmd_e c, logic src, byte_t b, key_t k);
    key_report_t want;
    // Idle the sender for a random number of cycles
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.src       <= src;
    in_ch.scan_byte <= b;
    in_ch.key_index <= k;
    // Hold the beat until the block takes it
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    beat_count++;
    if (c == CMD_CONSUME) consume_count++;
    want = track_beat(c, src, b, k);
    pending_reports.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic send_scan(logic src, byte_t b);
    send_beat(CMD_SCAN, src, b, key_t'($urandom_range(7)));
  endtask

  task automatic send_consume(logic src, key_t k);
    send_beat(CMD_CONSUME, src, byte_t'($urandom), k);
  endtask

  // Drop valid and wait for every owed report, then cover the pipeline depth
  task automatic settle;
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    reg_writes++;
    case (idx)
      CFG_ACTIVE_SOURCES: num_sources = val;
      CFG_CODE_SET_0: begin
        src_set[0]  = val;
        parse_st[0] = PS_IDLE;
      end
      CFG_CODE_SET_1: begin
        src_set[1]  = val;
        parse_st[1] = PS_IDLE;
      end
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [1:0] active, code_set_t cs0, code_set_t cs1);
    settle();
    write_reg(CFG_ACTIVE_SOURCES, active);
    write_reg(CFG_CODE_SET_0, cs0);
    write_reg(CFG_CODE_SET_1, cs1);
  endtask

  // ---------------------------------------------------------------------------
  // Random scan sequences
  // ---------------------------------------------------------------------------
  // Known key code of one family, now and then any byte. Set 1 family order:
  // arrows (extended too) then plain keys; set 2 family: extended arrows,
  // set 2 keys, then the set 3 extras.
  function automatic byte_t pick_code(logic set1_family, int top);
    int n;
    n = $urandom_range(top);
    if ($urandom_range(4) == 0) return byte_t'($urandom);
    if (set1_family) begin
      case (n)
        0: return 8'h48;
        1: return 8'h50;
        2: return 8'h4B;
        3: return 8'h4D;
        4: return 8'h11;
        5: return 8'h1F;
        6: return 8'h1E;
        7: return 8'h20;
        8: return 8'h13;
        default: return 8'h30;
      endcase
    end
    case (n)
      0: return 8'h75;
      1: return 8'h72;
      2: return 8'h6B;
      3: return 8'h74;
      4: return 8'h1D;
      5: return 8'h1B;
      6: return 8'h1C;
      7: return 8'h23;
      8: return 8'h2D;
      9: return 8'h32;
      10: return 8'h63;
      11: return 8'h60;
      12: return 8'h61;
      default: return 8'h6A;
    endcase
  endfunction

  task automatic push_bytes(byte_t b0, byte_t b1, byte_t b2, byte_t b3);
    word_q.push_back(b0);
    word_q.push_back(b1);
    word_q.push_back(b2);
    word_q.push_back(b3);
  endtask

  // Build one well-formed scan sequence for a code set, sometimes broken
  task automatic compose_word(code_set_t cs);
    int   form;
    logic brk;
    int   n;
    word_q.delete();
    form = $urandom_range(9);
    brk  = 1'($urandom_range(1));
    if (cs == CsSet1) begin
      case (form)
        0, 1, 2, 3: word_q.push_back(pick_code(1'b1, 9) | (brk ? BSet1Brk : 8'h00));
        4, 5: begin
          word_q.push_back(BExt);
          word_q.push_back(pick_code(1'b1, 3) | (brk ? BSet1Brk : 8'h00));
        end
        6: push_bytes(BExt, BFakeShft, BExt, 8'h37);
        7: begin
          // Release form, or a fake-shift break opening the make form
          if (brk) push_bytes(BExt, BPrtScRel, BExt, 8'hAA);
          else     push_bytes(BExt, 8'hAA, BExt, 8'h37);
        end
        8: begin
          push_bytes(BPause, 8'h1D, 8'h45, BPause);
          word_q.push_back(8'h9D);
          word_q.push_back(8'hC5);
        end
        default: word_q.push_back(byte_t'($urandom));
      endcase
    end else begin
      case (form)
        0, 1, 2, 3: begin
          if (brk) word_q.push_back(BBreak);
          word_q.push_back(pick_code(1'b0, (cs == CsSet3) ? 13 : 9));
        end
        4, 5: begin
          word_q.push_back(BExt);
          if (brk) word_q.push_back(BBreak);
          word_q.push_back(pick_code(1'b0, 3));
        end
        6: push_bytes(BExt, BS2FakeSh, BExt, BS2PrtSc);
        7: begin
          push_bytes(BExt, BBreak, BS2PrtSc, BExt);
          word_q.push_back(BBreak);
          word_q.push_back(BS2FakeSh);
        end
        8: begin
          push_bytes(BPause, 8'h14, 8'h77, BPause);
          push_bytes(BBreak, 8'h14, BBreak, 8'h77);
        end
        default: word_q.push_back(byte_t'($urandom));
      endcase
    end
    // Break one word in ten: cut it short or corrupt one byte
    if ($urandom_range(9) == 0 && word_q.size() > 1) begin
      if ($urandom_range(1)) begin
        n = $urandom_range(word_q.size() - 1, 1);
        while (word_q.size() > n) word_q.delete(word_q.size() - 1);
      end else begin
        word_q[$urandom_range(word_q.size() - 1)] = byte_t'($urandom);
      end
    end
  endtask

  // Send sequences to random keyboards, with consumes mixed in, until the
  // given number of beats has gone in
  task automatic run_traffic(int beats);
    int   target;
    logic src;
    target = beat_count + beats;
    while (beat_count < target) begin
      if ($urandom_range(99) < 15) begin
        send_consume(1'($urandom_range(1)), key_t'($urandom_range(7)));
      end else begin
        src = 1'($urandom_range(1));
        compose_word(src_set[src]);
        foreach (word_q[i]) begin
          if ($urandom_range(99) < 12)
            send_consume(1'($urandom_range(1)), key_t'($urandom_range(7)));
          send_scan(src, word_q[i]);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // No keyboard is attached out of reset, so a byte changes nothing
  task automatic test_ignored_after_reset;
    send_scan(1'b0, 8'h11);
  endtask

  // Set 1 on keyboard 0, set 2 on keyboard 1; a count of three enables both
  task automatic test_set1_decode;
    apply_config(2'd3, CsSet1, CsSet2);
    send_scan(1'b0, 8'h13);          // press R
    send_scan(1'b0, 8'h00);          // lowest byte: no key
    send_scan(1'b0, 8'hFF);          // highest byte: break of no key
    // Fake-shift break after E0 opens the print-screen make sequence
    send_scan(1'b0, BExt);
    send_scan(1'b0, 8'hAA);
    send_scan(1'b0, BExt);
    send_scan(1'b0, 8'h37);
    // A wrong byte inside the pause sequence is dropped and the parser idles
    send_scan(1'b0, BPause);
    send_scan(1'b0, 8'h1D);
    send_scan(1'b0, 8'h00);
  endtask

  task automatic test_set2_decode;
    // Break prefix ahead of E0 is ignored: this presses up
    send_scan(1'b1, BBreak);
    send_scan(1'b1, BExt);
    send_scan(1'b1, 8'h75);
    // Extended break of down, which is not held
    send_scan(1'b1, BExt);
    send_scan(1'b1, BBreak);
    send_scan(1'b1, 8'h72);
  endtask

  task automatic test_consume;
    send_consume(1'b0, KeyR);        // held: reads one, clears it
    send_consume(1'b0, 3'd7);        // beyond the last key: no effect
    send_consume(1'b1, KeyUp);
  endtask

  // Set 3 on keyboard 1; keyboard 0 switched off by code set zero
  task automatic test_set3_and_off;
    apply_config(2'd2, CsOff, CsSet3);
    send_scan(1'b1, 8'h63);          // press up
    send_scan(1'b1, BBreak);
    send_scan(1'b1, 8'h63);          // release up
    send_scan(1'b0, 8'h11);          // ignored: set off
  endtask

  // Random traffic across every pacing mode and a spread of register settings
  task automatic test_random_traffic(int beats_per_setting);
    for (int pace = 0; pace < 3; pace++) begin
      case (pace)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int setting = 0; setting < 6; setting++) begin
        case (setting)
          0: apply_config(2'd2, CsSet1, CsSet2);
          1: apply_config(2'd3, CsSet2, CsSet3);
          2: apply_config(2'd2, CsSet3, CsSet1);
          3: apply_config(2'd1, CsSet2, CsOff);
          4: apply_config(2'd2, CsOff, CsSet3);
          default: apply_config(2'd3, CsSet1, CsSet1);
        endcase
        run_traffic(beats_per_setting);
      end
    end
  endtask

  // Hold off the result side long enough that the pipeline fills and the
  // block must stall its input while the sender keeps offering beats
  task automatic test_output_stall;
    apply_config(2'd2, CsSet2, CsSet1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    stall_request = 150;
    @(negedge clk_i);
    run_traffic(24);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    int waited;
    rst_ni          = 1'b1;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_ACTIVE_SOURCES;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_SCAN;
    in_ch.src       = 1'b0;
    in_ch.scan_byte = '0;
    in_ch.key_index = '0;
    stall_request   = 0;
    fail_count      = 0;
    beat_count      = 0;
    consume_count   = 0;
    reg_writes      = 0;
    input_stalls    = 0;
    report_count    = 0;
    // Shadow state matches the block's reset
    held_mask   = '0;
    parse_st[0] = PS_IDLE;
    parse_st[1] = PS_IDLE;
    num_sources = 2'd0;
    src_set[0]  = CsSet1;
    src_set[1]  = CsSet1;
    send_idle_pct = 27;
    recv_idle_pct = 60;

    // Assert reset once every process is waiting on it
    #1 rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ignored_after_reset();
    test_set1_decode();
    test_set2_decode();
    test_consume();
    test_set3_and_off();
    test_random_traffic(60);
    test_output_stall();

    // Wait out anything still owed, bounded, then allow for the pipeline
    waited = 0;
    while (pending_reports.size() != 0 && waited < 2000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (5) @(negedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end

    $display("Run covered %0d beats (%0d consumes), %0d register writes, %0d input stalls.",
             beat_count, consume_count, reg_writes, input_stalls);
    $display("Code sets 0 to 3, one or both keyboards, three pacing modes, one long hold-off.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
